// ===== rtl/lphc_pkg.sv =====
// Shared constants, widths and control/status types for the hash counter.
package lphc_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int KEY_W     = 31;
    localparam int SLOT_W    = 11;
    localparam int THR_W     = 16;
    localparam int OUT_CNT_W = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int MULT_W    = 20;
    localparam int PROD_W    = KEY_W + MULT_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam logic [MULT_W-1:0] HASH_MULT = 20'd1000003;
    localparam logic [SLOT_W-1:0] SLOTS_RESET = 11'd1024;
    localparam logic [THR_W-1:0]  THR_RESET   = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'd1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic sweep_write;
        logic mem_read;
        logic probe_next;
        logic slot_write;
        logic result_load;
    } lphc_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic div_done;
        logic sweep_last;
        logic hit;
        logic probe_last;
        logic out_free;
    } lphc_status_t;

endpackage

// ===== rtl/lphc_ctrl.sv =====
// Sequencer for the hash counter: reset sweep, hashing, probing, clear and result hand-off.
module lphc_ctrl
    import lphc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  lphc_status_t st,
    output lphc_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_write = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (st.is_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (st.div_done)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_write = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (st.hit)
                begin
                    cmd.slot_write = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (st.probe_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/lphc_dp.sv =====
// Datapath: config registers, hash multiply, remainder divider, slot memory, output stage.
module lphc_dp
    import lphc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lphc_cmd_t            cmd,
    output lphc_status_t         st,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 command,
    input  logic [KEY_W-1:0]     key,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_W-1:0]     echoed_key,
    output logic [OUT_CNT_W-1:0] new_count,
    output logic                 reached_threshold,
    output logic                 table_full
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 1 + KEY_W + COUNT_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    // configuration
    logic [SLOT_W-1:0] table_slots_reg;
    logic [THR_W-1:0]  threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_slots_reg <= SLOTS_RESET;
            threshold_reg   <= THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TABLE_SLOTS: table_slots_reg <= cfg_data[SLOT_W-1:0];
                REG_THRESHOLD:   threshold_reg   <= cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    // slots in use, clamped to 1..TABLE_DEPTH
    logic [SLOT_W-1:0] slots_eff;

    always_comb
    begin
        if (table_slots_reg == '0)
        begin
            slots_eff = SLOT_W'(1);
        end
        else if (32'(table_slots_reg) > 32'(TABLE_DEPTH))
        begin
            slots_eff = SLOT_W'(TABLE_DEPTH);
        end
        else
        begin
            slots_eff = table_slots_reg;
        end
    end

    // item capture, hash product and restoring remainder
    logic                 clear_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [SLOT_W-1:0]    probe_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SLOT_W:0]      trial;
    logic [SLOT_W-1:0]    pos_inc;

    assign trial   = {pos_reg, prod_reg[PROD_W-1]};
    assign pos_inc = pos_reg + SLOT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            clear_reg <= command;
            key_reg   <= key;
            prod_reg  <= PROD_W'(key) * PROD_W'(HASH_MULT);
            pos_reg   <= '0;
            probe_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, slots_eff})
            begin
                pos_reg <= SLOT_W'(trial - {1'b0, slots_eff});
            end
            else
            begin
                pos_reg <= trial[SLOT_W-1:0];
            end
        end
        else if (cmd.probe_next)
        begin
            probe_reg <= probe_reg + SLOT_W'(1);
            pos_reg   <= (pos_inc == slots_eff) ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            div_cnt_reg <= DIV_CNT_W'(PROD_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    // sweep address for reset and clear passes
    logic [ADDR_W-1:0] sweep_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_addr_reg <= (sweep_addr_reg == LAST_ADDR) ? '0
                                                            : sweep_addr_reg + ADDR_W'(1);
        end
    end

    // slot memory: {valid, key, count}
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  pos_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;

    logic                  rd_vld;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] base_cnt;
    logic [COUNT_BITS-1:0] upd_cnt;
    logic                  bumped;
    logic                  hit;

    assign pos_addr = ADDR_W'(pos_reg);
    assign rd_vld   = rd_data_reg[ENTRY_W-1];
    assign rd_key   = rd_data_reg[COUNT_BITS +: KEY_W];
    assign rd_cnt   = rd_data_reg[COUNT_BITS-1:0];
    assign hit      = !rd_vld || (rd_key == key_reg);
    assign base_cnt = rd_vld ? rd_cnt : '0;
    assign bumped   = (base_cnt != '1);
    assign upd_cnt  = bumped ? base_cnt + COUNT_BITS'(1) : base_cnt;

    assign wr_en   = cmd.sweep_write || cmd.slot_write;
    assign wr_addr = cmd.sweep_write ? sweep_addr_reg : pos_addr;
    assign wr_data = cmd.sweep_write ? '0 : {1'b1, key_reg, upd_cnt};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[pos_addr];
        end
    end

    // output stage
    logic                 out_valid_reg;
    logic [KEY_W-1:0]     out_key_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic                 out_thr_reg;
    logic                 out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            if (clear_reg == CMD_CLEAR)
            begin
                out_key_reg  <= '0;
                out_cnt_reg  <= '0;
                out_thr_reg  <= 1'b0;
                out_full_reg <= 1'b0;
            end
            else if (!hit)
            begin
                out_key_reg  <= key_reg;
                out_cnt_reg  <= '0;
                out_thr_reg  <= 1'b0;
                out_full_reg <= 1'b1;
            end
            else
            begin
                out_key_reg  <= key_reg;
                out_cnt_reg  <= OUT_CNT_W'(upd_cnt);
                out_thr_reg  <= bumped && (32'(upd_cnt) == 32'(threshold_reg));
                out_full_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign echoed_key        = out_key_reg;
    assign new_count         = out_cnt_reg;
    assign reached_threshold = out_thr_reg;
    assign table_full        = out_full_reg;

    // status to the sequencer
    assign st.is_clear   = (clear_reg == CMD_CLEAR);
    assign st.div_done   = (div_cnt_reg == '0);
    assign st.sweep_last = (sweep_addr_reg == LAST_ADDR);
    assign st.hit        = hit;
    assign st.probe_last = (probe_reg == slots_eff - SLOT_W'(1));
    assign st.out_free   = !out_valid_reg || !out_stall;

endmodule

// ===== rtl/linear_probe_hash_counter.sv =====
// Count word: after accept, the 51-step remainder unit finds the home slot, then each probed
// slot is read into a register (ST_READ) and checked (ST_CHECK) until a hit or a full table.
// Clear word: one memory entry emptied per cycle over all TABLE_DEPTH entries, then the result.
// One word at a time: the next word can be taken in the cycle after the result loads.
// After reset the block sweeps all TABLE_DEPTH slots empty before it accepts a word.
module linear_probe_hash_counter
    import lphc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [KEY_W-1:0]     key,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_W-1:0]     echoed_key,
    output logic [OUT_CNT_W-1:0] new_count,
    output logic                 reached_threshold,
    output logic                 table_full
);

    lphc_cmd_t    cmd;
    lphc_status_t st;

    // Sequencer: hold the input stalled outside idle, step the divider, walk the
    // probe chain, and drop the result into the output stage once it is free.
    lphc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: hash = key * 1000003 mod slots, linear probe with wrap, saturating
    // count update, and a sweep that empties every slot on clear and after reset.
    lphc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .key               (key),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .echoed_key        (echoed_key),
        .new_count         (new_count),
        .reached_threshold (reached_threshold),
        .table_full        (table_full)
    );

endmodule

// ===== sim/linear_probe_hash_counter_test.sv =====
// Self-checking testbench for the linear-probe hash counter: directed and random words.
module linear_probe_hash_counter_test;
    import lphc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous cycle ceiling. It covers the reset sweep, about 40 full-table clears,
    // about 1300 count words with probe chains and random idling on both sides.
    localparam int unsigned LIMIT_CYCLES = 4_000_000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned WORDS_PER_PHASE = 156;
    localparam int unsigned POOL_MAX = 48;

    // One expected result word.
    typedef struct packed {
        logic [KEY_W-1:0]     echoed;
        logic [OUT_CNT_W-1:0] count;
        logic                 at_thr;
        logic                 full;
    } tally_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TABLE_SLOTS;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 command   = CMD_COUNT;
    logic [KEY_W-1:0]     key       = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KEY_W-1:0]     echoed_key;
    logic [OUT_CNT_W-1:0] new_count;
    logic                 reached_threshold;
    logic                 table_full;

    // Shadow copy of the hash table and its two registers.
    logic [SLOT_W-1:0]         slots_cfg = SLOTS_RESET;
    logic [THR_W-1:0]          thr_cfg   = THR_RESET;
    bit                        slot_used  [TABLE_DEPTH_DEF];
    logic [KEY_W-1:0]          slot_key   [TABLE_DEPTH_DEF];
    logic [COUNT_BITS_DEF-1:0] slot_count [TABLE_DEPTH_DEF];

    tally_t      pending_tallies[$];
    tally_t      want;
    int unsigned errors       = 0;
    int unsigned cycle_count  = 0;
    bit          sender_idles = 1'b1;
    bit          stall_enable = 1'b1;

    linear_probe_hash_counter u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .key               (key),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .echoed_key        (echoed_key),
        .new_count         (new_count),
        .reached_threshold (reached_threshold),
        .table_full        (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted word to the shadow table and return the result it must produce.
    function automatic tally_t tally_word(input logic cmd, input logic [KEY_W-1:0] k);
        tally_t                    res;
        int unsigned               span;
        int unsigned               pos;
        int unsigned               probes;
        longint unsigned           prod;
        logic [COUNT_BITS_DEF-1:0] cnt;
        bit                        landed;
        bit                        bumped;
        res = '0;
        if (cmd == CMD_CLEAR)
        begin
            // clear empties every slot, even those beyond the current slot count
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            return res;
        end
        // a slot count of zero acts as one, anything above the depth acts as the depth
        span = slots_cfg;
        if (span < 1)
            span = 1;
        if (span > TABLE_DEPTH_DEF)
            span = TABLE_DEPTH_DEF;
        prod = 64'(k) * 64'(HASH_MULT);
        pos = 32'(prod % 64'(span));
        landed = 1'b0;
        for (probes = 0; probes < span; probes++)
        begin
            if (!slot_used[pos] || slot_key[pos] == k)
            begin
                landed = 1'b1;
                break;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        res.echoed = k;
        if (!landed)
        begin
            // every probed slot holds some other key: report full, change nothing
            res.full = 1'b1;
            return res;
        end
        cnt = slot_used[pos] ? slot_count[pos] : '0;
        // saturate: a hit on a maxed-out slot keeps its count and never reports the threshold
        bumped = (cnt != '1);
        if (bumped)
            cnt = cnt + 1'b1;
        slot_used[pos]  = 1'b1;
        slot_key[pos]   = k;
        slot_count[pos] = cnt;
        res.count  = cnt;
        res.at_thr = bumped && (cnt == thr_cfg);
        return res;
    endfunction

    // Drive one word; hold it until the block takes it, then log its expected result.
    // Leave in_valid high on return so back-to-back words need no second assignment.
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] k);
        int unsigned gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, 60);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_tallies.push_back(tally_word(cmd, k));
    endtask

    // Drop valid and wait until every expected result is back, then let the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tallies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_TABLE_SLOTS)
            slots_cfg = data[SLOT_W-1:0];
        else
            thr_cfg = data[THR_W-1:0];
    endtask

    // Reset settings: key extremes, alternating bit patterns, a repeat hit, and a clear
    // whose key field is nonzero and must be ignored.
    task automatic test_basic_counts();
        send_word(CMD_COUNT, '0);
        send_word(CMD_COUNT, '1);
        send_word(CMD_COUNT, '0);
        send_word(CMD_COUNT, 31'h5555_5555);
        send_word(CMD_COUNT, 31'h2AAA_AAAA);
        send_word(CMD_CLEAR, '1);
        send_word(CMD_COUNT, '0);
    endtask

    // Report exactly at the threshold, not after; a zero threshold never reports.
    task automatic test_threshold();
        drain_results();
        write_register(REG_THRESHOLD, 16'd3);
        repeat (4) send_word(CMD_COUNT, 31'd12345);
        drain_results();
        write_register(REG_THRESHOLD, 16'd0);
        repeat (2) send_word(CMD_COUNT, 31'd777);
    endtask

    // Fill a tiny table until it overflows, shrink and regrow it over live entries,
    // then try the out-of-range slot counts (zero, and upper data bits set).
    task automatic test_full_and_resize();
        drain_results();
        write_register(REG_TABLE_SLOTS, 16'd4);
        send_word(CMD_CLEAR, '0);
        send_word(CMD_COUNT, 31'd101);
        send_word(CMD_COUNT, 31'd202);
        send_word(CMD_COUNT, 31'd303);
        send_word(CMD_COUNT, 31'd404);
        send_word(CMD_COUNT, 31'd505);
        send_word(CMD_COUNT, 31'd202);
        drain_results();
        write_register(REG_TABLE_SLOTS, 16'd2);
        send_word(CMD_COUNT, 31'd202);
        drain_results();
        write_register(REG_TABLE_SLOTS, 16'd4);
        send_word(CMD_COUNT, 31'd404);
        drain_results();
        write_register(REG_TABLE_SLOTS, 16'd0);
        send_word(CMD_CLEAR, '0);
        send_word(CMD_COUNT, 31'd7);
        send_word(CMD_COUNT, 31'd8);
        drain_results();
        write_register(REG_TABLE_SLOTS, 16'hFFFF);
        send_word(CMD_COUNT, 31'd7);
    endtask

    // Random phases, each with its own slot count and threshold. Most keys come from a
    // small pool so hits, threshold reports and full tables are common; the rest are
    // fresh 31-bit keys. One phase runs with no idling on either side.
    task automatic test_random_traffic();
        int               plan_slots [RANDOM_PHASES];
        int               plan_thr   [RANDOM_PHASES];
        logic [KEY_W-1:0] key_pool   [POOL_MAX];
        int unsigned      pool_n;
        int unsigned      pick;
        plan_slots = '{1024, 8, 64, 3, 16, 200, 1, 40};
        plan_thr   = '{1, 2, 3, 1, 65535, 4, 0, 2};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            write_register(REG_TABLE_SLOTS, 16'(plan_slots[ph]));
            write_register(REG_THRESHOLD, 16'(plan_thr[ph]));
            sender_idles = (ph != 5);
            stall_enable = (ph != 5);
            pool_n = plan_slots[ph] + 2;
            if (pool_n > POOL_MAX)
                pool_n = POOL_MAX;
            for (int i = 0; i < POOL_MAX; i++)
                key_pool[i] = KEY_W'($urandom);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // hold off mid-phase until every result is back, then resume
                if (ph == 3 && n == WORDS_PER_PHASE / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_word(CMD_CLEAR, KEY_W'($urandom));
                else if (pick < 83)
                    send_word(CMD_COUNT, key_pool[$urandom_range(0, pool_n - 1)]);
                else
                    send_word(CMD_COUNT, KEY_W'($urandom));
            end
        end
        sender_idles = 1'b1;
        stall_enable = 1'b1;
    endtask

    // Stall the result side about one cycle in ten while stall_enable is set.
    always @(posedge clk)
    begin
        out_stall <= stall_enable && ($urandom_range(0, 99) < 10);
    end

    // Compare each accepted result word with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tallies.size() == 0)
            begin
                $error("result word with nothing expected: echoed_key %0d", echoed_key);
                errors++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                if (echoed_key !== want.echoed)
                begin
                    $error("echoed_key: expected %0d, got %0d", want.echoed, echoed_key);
                    errors++;
                end
                if (new_count !== want.count)
                begin
                    $error("new_count: expected %0d, got %0d", want.count, new_count);
                    errors++;
                end
                if (reached_threshold !== want.at_thr)
                begin
                    $error("reached_threshold: expected %0b, got %0b",
                           want.at_thr, reached_threshold);
                    errors++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0b, got %0b", want.full, table_full);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_counts();
        test_threshold();
        test_full_and_resize();
        test_random_traffic();
        drain_results();
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
